[rtl/fisa_pkg.sv]
// Package for the floppy interface signal adapter.
// Holds the shared types, mode codes and track constants. No dependencies.
`timescale 1ns / 1ps

package fisa_pkg;

	localparam int TRACK_W = 7;
	localparam logic [TRACK_W-1:0] TRACK_LIMIT   = 7'd80;
	localparam logic [TRACK_W-1:0] MAX_TRACK_RST = 7'd76;
	localparam logic [TRACK_W-1:0] TRACK_TG_LOW  = 7'd44;
	localparam logic [TRACK_W-1:0] TRACK_TG_HIGH = 7'd60;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TG43_MODE    = 2'd0,
		CFG_HEAD_LOAD    = 2'd1,
		CFG_READY_CHANGE = 2'd2,
		CFG_MAX_TRACK    = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		TG_WRITE_44 = 3'd0,
		TG_READ_44  = 3'd1,
		TG_ANY_44   = 3'd2,
		TG_READ_60  = 3'd3,
		TG_WR44_RD60 = 3'd4,
		TG_ON       = 3'd5,
		TG_OFF      = 3'd6,
		TG_EXT      = 3'd7
	} tg43_mode_t;

	typedef enum logic [1:0] {
		HL_MOTOR = 2'd0,
		HL_ON    = 2'd1,
		HL_OFF   = 2'd2,
		HL_EXT   = 2'd3
	} head_load_mode_t;

	typedef enum logic [3:0] {
		RC_READY         = 4'd0,
		RC_NOT_CHG       = 4'd1,
		RC_READY_NOT_CHG = 4'd2,
		RC_READY_OR_NCHG = 4'd3,
		RC_NOT_READY     = 4'd4,
		RC_CHG           = 4'd5,
		RC_NRDY_AND_CHG  = 4'd6,
		RC_NRDY_OR_CHG   = 4'd7,
		RC_ON            = 4'd8,
		RC_OFF           = 4'd9,
		RC_EXT           = 4'd10
	} ready_change_mode_t;

	typedef struct packed {
		tg43_mode_t         tg43_mode;
		head_load_mode_t    head_load_mode;
		ready_change_mode_t ready_change_mode;
		logic [TRACK_W-1:0] max_track;
	} cfg_t;

	typedef struct packed {
		logic device_select_n;
		logic motor_enable_n;
		logic direction_n;
		logic step_n;
		logic write_gate_n;
		logic track_zero_n;
		logic ready_n;
		logic disk_change_n;
		logic external_level;
		logic step_event;
		logic track_zero_event;
	} pins_t;

	typedef struct packed {
		logic               tg43_out_n;
		logic               head_load_out_n;
		logic               ready_change_out_n;
		logic [TRACK_W-1:0] track_now;
	} result_t;

endpackage

[rtl/fisa_track.sv]
// Head track counter: holds the current track and works out the track after a sample.
// Depends on fisa_pkg.
`timescale 1ns / 1ps

module fisa_track (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  fisa_pkg::pins_t             pins,
	input  logic [fisa_pkg::TRACK_W-1:0] max_track,
	output logic [fisa_pkg::TRACK_W-1:0] track_next
);
	import fisa_pkg::*;

	logic [TRACK_W-1:0] track_q;
	logic [TRACK_W-1:0] limit;
	logic [TRACK_W-1:0] stepped;
	logic               do_step;
	logic               do_clear;

	assign limit    = (max_track > TRACK_LIMIT) ? TRACK_LIMIT : max_track;
	assign do_step  = !pins.device_select_n && pins.step_event && !pins.step_n
	                  && pins.write_gate_n;
	assign do_clear = !pins.device_select_n && pins.track_zero_event && !pins.track_zero_n;

	always_comb begin
		stepped = track_q;
		if (do_step) begin
			if (!pins.direction_n) begin
				// inward: clamp, also pulls a track above a lowered limit back down
				stepped = (track_q >= limit) ? limit : track_q + 7'd1;
			end else if (track_q != '0) begin
				stepped = track_q - 7'd1;
			end
		end
		track_next = do_clear ? '0 : stepped;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= '0;
		end else if (advance) begin
			track_q <= track_next;
		end
	end

	a_track_range: assert property (@(posedge clk) disable iff (!arst_n)
		track_q <= TRACK_LIMIT)
		else $error("track above limit");

	a_track_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(track_q))
		else $error("track moved without an item");

	a_desel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pins.device_select_n |=> $stable(track_q))
		else $error("track moved while deselected");

	a_tz_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && do_clear |=> track_q == '0)
		else $error("track zero event did not clear track");

endmodule

[rtl/fisa_outsel.sv]
// Output line selection: TG43, head load and ready/disk-change from the mode registers.
// Depends on fisa_pkg.
`timescale 1ns / 1ps

module fisa_outsel (
	input  fisa_pkg::pins_t             pins,
	input  fisa_pkg::cfg_t              cfg,
	input  logic [fisa_pkg::TRACK_W-1:0] track,
	output fisa_pkg::result_t           res
);
	import fisa_pkg::*;

	logic writing, motor, rdy, chg, ext, at44, at60;
	logic tg_act, hl_act, rc_act;

	assign writing = !pins.write_gate_n;
	assign motor   = !pins.motor_enable_n;
	assign rdy     = !pins.ready_n;
	assign chg     = !pins.disk_change_n;
	assign ext     = pins.external_level;
	assign at44    = track >= TRACK_TG_LOW;
	assign at60    = track >= TRACK_TG_HIGH;

	always_comb begin
		case (cfg.tg43_mode)
			TG_WRITE_44:  tg_act = writing && at44;
			TG_READ_44:   tg_act = !writing && at44;
			TG_ANY_44:    tg_act = at44;
			TG_READ_60:   tg_act = !writing && at60;
			TG_WR44_RD60: tg_act = writing ? at44 : at60;
			TG_ON:        tg_act = 1'b1;
			TG_OFF:       tg_act = 1'b0;
			TG_EXT:       tg_act = ext;
			default:      tg_act = 1'b0;
		endcase
	end

	always_comb begin
		case (cfg.head_load_mode)
			HL_MOTOR: hl_act = motor;
			HL_ON:    hl_act = 1'b1;
			HL_OFF:   hl_act = 1'b0;
			HL_EXT:   hl_act = ext;
			default:  hl_act = 1'b0;
		endcase
	end

	always_comb begin
		case (cfg.ready_change_mode)
			RC_READY:         rc_act = rdy;
			RC_NOT_CHG:       rc_act = !chg;
			RC_READY_NOT_CHG: rc_act = rdy && !chg;
			RC_READY_OR_NCHG: rc_act = rdy || !chg;
			RC_NOT_READY:     rc_act = !rdy;
			RC_CHG:           rc_act = chg;
			RC_NRDY_AND_CHG:  rc_act = !rdy && chg;
			RC_NRDY_OR_CHG:   rc_act = !rdy || chg;
			RC_ON:            rc_act = 1'b1;
			RC_OFF:           rc_act = 1'b0;
			RC_EXT:           rc_act = ext;
			default:          rc_act = 1'b0; // unused codes leave the line inactive
		endcase
	end

	// deselected drive: every line inactive (high)
	always_comb begin
		res.tg43_out_n         = pins.device_select_n | !tg_act;
		res.head_load_out_n    = pins.device_select_n | !hl_act;
		res.ready_change_out_n = pins.device_select_n | !rc_act;
		res.track_now          = track;
	end

endmodule

[rtl/floppy_interface_signal_adapter.sv]
// Floppy interface signal adapter, top level: stream ports, mode registers, pipeline.
// An item accepted on the slave side passes the input register, then the result register,
// before its result shows on the master side; a master stall holds it in the input register.
// Throughput: one item per cycle while the master side accepts; track_next is combinational.
// Reset (arst_n low, asynchronous): track to 0, modes to 0, max_track to 76,
// both pipeline stages empty.
// Depends on fisa_pkg, fisa_track and fisa_outsel.
`timescale 1ns / 1ps

module floppy_interface_signal_adapter (
	input  logic                              clk,
	input  logic                              arst_n,
	// tdata, lowest bit up: device_select_n, motor_enable_n, direction_n, step_n,
	// write_gate_n, track_zero_n, ready_n, disk_change_n, external_level,
	// step_event, track_zero_event, zero fill
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [fisa_pkg::IN_TDATA_W-1:0]   s_tdata,
	// tdata, lowest bit up: tg43_out_n, head_load_out_n, ready_change_out_n,
	// track_now[6:0], zero fill
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [fisa_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                              cfg_we,
	input  logic [fisa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fisa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fisa_pkg::*;

	cfg_t               cfg_q;
	pins_t              pins_in;
	pins_t              pins_s1;
	logic               valid_s1;
	logic               out_free;
	logic               advance;
	logic [TRACK_W-1:0] track_next;
	result_t            res_d;
	result_t            res_q;
	logic               out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tg43_mode         <= TG_WRITE_44;
			cfg_q.head_load_mode    <= HL_MOTOR;
			cfg_q.ready_change_mode <= RC_READY;
			cfg_q.max_track         <= MAX_TRACK_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_TG43_MODE:    cfg_q.tg43_mode <= tg43_mode_t'(cfg_data[2:0]);
				CFG_HEAD_LOAD:    cfg_q.head_load_mode <= head_load_mode_t'(cfg_data[1:0]);
				CFG_READY_CHANGE: cfg_q.ready_change_mode <= ready_change_mode_t'(cfg_data[3:0]);
				CFG_MAX_TRACK:    cfg_q.max_track <= cfg_data[TRACK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pins_in.device_select_n  = s_tdata[0];
		pins_in.motor_enable_n   = s_tdata[1];
		pins_in.direction_n      = s_tdata[2];
		pins_in.step_n           = s_tdata[3];
		pins_in.write_gate_n     = s_tdata[4];
		pins_in.track_zero_n     = s_tdata[5];
		pins_in.ready_n          = s_tdata[6];
		pins_in.disk_change_n    = s_tdata[7];
		pins_in.external_level   = s_tdata[8];
		pins_in.step_event       = s_tdata[9];
		pins_in.track_zero_event = s_tdata[10];
	end

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			pins_s1 <= pins_in;
		end
	end

	fisa_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.pins       (pins_s1),
		.max_track  (cfg_q.max_track),
		.track_next (track_next)
	);

	fisa_outsel u_outsel (
		.pins  (pins_s1),
		.cfg   (cfg_q),
		.track (track_next),
		.res   (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - 3 - TRACK_W){1'b0}}, res_q.track_now,
	                   res_q.ready_change_out_n, res_q.head_load_out_n, res_q.tg43_out_n};

	a_desel_lines: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pins_s1.device_select_n |=> m_tdata[2:0] == 3'b111)
		else $error("deselected item drove an active line");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("item lost between stages");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule
